### hw/rtl/tama_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tama_pkg
// Types and fixed widths shared by the three-axis moving average core.
// ----------------------------------------------------------------------------
package tama_pkg;

	localparam int SAMPLE_W = 16;
	localparam int AXES     = 3;
	localparam int ENTRY_W  = SAMPLE_W * AXES;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_x;
		logic signed [SAMPLE_W-1:0] sample_y;
		logic signed [SAMPLE_W-1:0] sample_z;
		logic                       restart;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean_x;
		logic signed [SAMPLE_W-1:0] mean_y;
		logic signed [SAMPLE_W-1:0] mean_z;
	} mean_t;

endpackage

### hw/rtl/three_axis_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_core
// Boxcar moving average over the last WINDOW_SIZE samples of three axes.
// ----------------------------------------------------------------------------
// One item in, one item out; a sample is taken every cycle unless sample_stall
// is high. The history is one single-port read-first memory of WINDOW_SIZE
// entries, read at the pointer when a sample is accepted and written there
// unless that sample fills the window; a running sum per axis is updated by
// adding the new sample and dropping the oldest one. The first sample after
// reset, or one marked restart, fills the window: entries not yet overwritten
// since then read as that sample, so no clearing pass is ever needed. The mean
// is truncated toward zero; division by WINDOW_SIZE is a multiply by a
// precomputed reciprocal, registered before the final shift and sign fix.
module three_axis_moving_average_core #(
	parameter int WINDOW_SIZE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  tama_pkg::sample_t sample,
	output logic              mean_valid,
	input  logic              mean_stall,
	output tama_pkg::mean_t   mean
);
	import tama_pkg::*;

	localparam int LOG_W   = $clog2(WINDOW_SIZE);
	localparam int PTR_W   = LOG_W;
	localparam int SUM_W   = SAMPLE_W + LOG_W;
	localparam int SHIFT   = SUM_W + LOG_W;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	// ceil(2^SHIFT / WINDOW_SIZE): exact floor division for any SUM_W-bit magnitude
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);

	// window state
	logic [ENTRY_W-1:0]  mem [WINDOW_SIZE];
	logic [PTR_W-1:0]    ptr_q;
	logic                primed_q;
	logic                fresh_q;
	logic [ENTRY_W-1:0]  fill_q;
	logic signed [SUM_W-1:0] sum_q [AXES];

	// stage 1
	logic                v1_q;
	logic [ENTRY_W-1:0]  smp_s1;
	logic                rst_s1;
	logic                use_fill_s1;
	logic [ENTRY_W-1:0]  fill_s1;
	logic [ENTRY_W-1:0]  rd_s1;

	// stage 2
	logic                v2_q;
	logic signed [SUM_W-1:0] sum_s2 [AXES];

	// stage 3
	logic                v3_q;
	logic [PROD_W-1:0]   prod_s3 [AXES];
	logic                neg_s3 [AXES];

	// output
	logic                out_v_q;
	logic [ENTRY_W-1:0]  out_q;

	logic                adv1, adv2, adv3, rdy_out;
	logic                acc;
	logic                rst_eff;
	logic [ENTRY_W-1:0]  smp_in;
	logic [ENTRY_W-1:0]  old_s1;
	logic signed [SUM_W-1:0] sum_nxt [AXES];
	logic [SUM_W-1:0]    mag [AXES];
	logic [SAMPLE_W-1:0] quo [AXES];
	logic [SAMPLE_W-1:0] res [AXES];

	assign rdy_out      = !out_v_q || !mean_stall;
	assign adv3         = !v3_q || rdy_out;
	assign adv2         = !v2_q || adv3;
	assign adv1         = !v1_q || adv2;
	assign sample_stall = !adv1;
	assign acc          = sample_valid && adv1;
	assign rst_eff      = sample.restart || !primed_q;
	assign smp_in       = {sample.sample_z, sample.sample_y, sample.sample_x};
	assign old_s1       = use_fill_s1 ? fill_s1 : rd_s1;

	// history memory, read-first
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[ptr_q];
			if (!rst_eff) begin
				mem[ptr_q] <= smp_in;
			end
		end
	end

	// window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			primed_q <= 1'b0;
			fresh_q  <= 1'b0;
		end else if (acc) begin
			primed_q <= 1'b1;
			if (rst_eff) begin
				ptr_q   <= '0;
				fresh_q <= 1'b1;
			end else if (ptr_q == PTR_W'(WINDOW_SIZE - 1)) begin
				ptr_q   <= '0;
				fresh_q <= 1'b0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			smp_s1      <= smp_in;
			rst_s1      <= rst_eff;
			use_fill_s1 <= fresh_q;
			fill_s1     <= fill_q;
			if (rst_eff) begin
				fill_q <= smp_in;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			if (rst_s1) begin
				sum_nxt[a] = {{LOG_W{smp_s1[a*SAMPLE_W + SAMPLE_W-1]}},
					smp_s1[a*SAMPLE_W +: SAMPLE_W]} * SUM_W'(WINDOW_SIZE);
			end else begin
				sum_nxt[a] = sum_q[a]
					+ {{LOG_W{smp_s1[a*SAMPLE_W + SAMPLE_W-1]}},
						smp_s1[a*SAMPLE_W +: SAMPLE_W]}
					- {{LOG_W{old_s1[a*SAMPLE_W + SAMPLE_W-1]}},
						old_s1[a*SAMPLE_W +: SAMPLE_W]};
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mag[a] = sum_s2[a][SUM_W-1] ? SUM_W'(-sum_s2[a]) : SUM_W'(sum_s2[a]);
			quo[a] = prod_s3[a][SHIFT +: SAMPLE_W];
			res[a] = neg_s3[a] ? SAMPLE_W'(-quo[a]) : quo[a];
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			out_v_q <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			if (adv1) begin
				v1_q <= sample_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
				if (v1_q) begin
					for (int a = 0; a < AXES; a++) begin
						sum_q[a] <= sum_nxt[a];
					end
				end
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
			if (rdy_out) begin
				out_v_q <= v3_q;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			for (int a = 0; a < AXES; a++) begin
				sum_s2[a] <= sum_nxt[a];
			end
		end
		if (adv3 && v2_q) begin
			for (int a = 0; a < AXES; a++) begin
				prod_s3[a] <= PROD_W'(mag[a]) * PROD_W'(RECIP[RECIP_W-1:0]);
				neg_s3[a]  <= sum_s2[a][SUM_W-1];
			end
		end
		if (rdy_out && v3_q) begin
			out_q <= {res[2], res[1], res[0]};
		end
	end

	assign mean_valid  = out_v_q;
	assign mean.mean_x = out_q[0*SAMPLE_W +: SAMPLE_W];
	assign mean.mean_y = out_q[1*SAMPLE_W +: SAMPLE_W];
	assign mean.mean_z = out_q[2*SAMPLE_W +: SAMPLE_W];

	// checks
	a_fresh_primed: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> primed_q)
		else $error("fill window marked while not primed");

	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> ptr_q == '0)
		else $error("pointer moved before window primed");

	a_prime_fills: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(primed_q) |-> fresh_q && ptr_q == '0)
		else $error("first item did not fill the window");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v1_q && v2_q && v3_q && out_v_q)
		else $error("input stalled with room in the pipeline");

endmodule

### tb/three_axis_moving_average_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_moving_average_core_tb
// Drives three-axis samples through the moving average core and compares every
// mean item with a boxcar average kept in the bench, or with the typed mean of
// its table row. A short table covers the empty window, restarts, extreme
// values and truncation toward zero. Random phases follow, with sender gaps,
// receiver stalls, a long output hold-off and full drains between phases.
// ----------------------------------------------------------------------------
module three_axis_moving_average_core_tb;

	import tama_pkg::*;

	localparam int WINDOW     = 64;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASE_ITEMS = 190;

	typedef struct {
		sample_t s;
		bit      typed;
		mean_t   m;
	} plan_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample_item = '0;
	logic    mean_valid;
	logic    mean_stall = 1'b0;
	mean_t   mean_item;

	// typed expectation travels with the item it belongs to
	bit      row_typed = 1'b0;
	mean_t   row_mean = '0;

	// bench copy of the filter state
	logic signed [SAMPLE_W-1:0] win_hist [WINDOW][AXES];
	longint                     axis_sums [AXES];
	int                         oldest_idx;
	bit                         win_full;

	mean_t   expected_means [$];
	int      errors = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 0;
	int      rx_stall_pct = 0;
	int      hold_len = 0;

	plan_row_t plan [16];

	three_axis_moving_average_core #(.WINDOW_SIZE(WINDOW)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample_item),
		.mean_valid   (mean_valid),
		.mean_stall   (mean_stall),
		.mean         (mean_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("three_axis_moving_average_core_tb NOT OK");
			$finish;
		end
	end

	function automatic void clear_average();
		oldest_idx = 0;
		win_full = 1'b0;
		for (int a = 0; a < AXES; a++)
			axis_sums[a] = 0;
	endfunction

	function automatic mean_t average_step(sample_t s);
		logic signed [SAMPLE_W-1:0] v [AXES];
		mean_t m;
		v[0] = s.sample_x;
		v[1] = s.sample_y;
		v[2] = s.sample_z;
		if (!win_full || s.restart) begin
			// empty window or restart: every slot takes this sample
			for (int i = 0; i < WINDOW; i++)
				for (int a = 0; a < AXES; a++)
					win_hist[i][a] = v[a];
			for (int a = 0; a < AXES; a++)
				axis_sums[a] = longint'(v[a]) * WINDOW;
			oldest_idx = 0;
			win_full = 1'b1;
		end else begin
			for (int a = 0; a < AXES; a++) begin
				axis_sums[a] += longint'(v[a]) - longint'(win_hist[oldest_idx][a]);
				win_hist[oldest_idx][a] = v[a];
			end
			oldest_idx = (oldest_idx + 1) % WINDOW;
		end
		// signed division truncates toward zero
		m.mean_x = SAMPLE_W'(axis_sums[0] / WINDOW);
		m.mean_y = SAMPLE_W'(axis_sums[1] / WINDOW);
		m.mean_z = SAMPLE_W'(axis_sums[2] / WINDOW);
		return m;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// input acceptance first, then the output check
	always @(posedge clk) begin
		mean_t m;
		mean_t want;
		if (arst_n && sample_valid && !sample_stall) begin
			m = average_step(sample_item);
			expected_means.push_back(row_typed ? row_mean : m);
		end
		if (arst_n && mean_valid && !mean_stall) begin
			if (expected_means.size() == 0) begin
				report_mismatch("unexpected mean item", 0, 0);
			end else begin
				want = expected_means.pop_front();
				if (mean_item.mean_x !== want.mean_x)
					report_mismatch("mean_x", mean_item.mean_x, want.mean_x);
				if (mean_item.mean_y !== want.mean_y)
					report_mismatch("mean_y", mean_item.mean_y, want.mean_y);
				if (mean_item.mean_z !== want.mean_z)
					report_mismatch("mean_z", mean_item.mean_z, want.mean_z);
			end
		end
	end

	// receiver: random stalls, or one long hold-off counted here
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				mean_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				mean_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	function automatic plan_row_t row(int x, int y, int z, bit r, bit typed,
			int mx = 0, int my = 0, int mz = 0);
		plan_row_t p;
		p.s.sample_x = SAMPLE_W'(x);
		p.s.sample_y = SAMPLE_W'(y);
		p.s.sample_z = SAMPLE_W'(z);
		p.s.restart = r;
		p.typed = typed;
		p.m.mean_x = SAMPLE_W'(mx);
		p.m.mean_y = SAMPLE_W'(my);
		p.m.mean_z = SAMPLE_W'(mz);
		return p;
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_axis();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return SAMPLE_W'($urandom_range(65535));
		if (pick < 75)
			return $urandom_range(1) ? 16'h7fff : 16'h8000;
		return SAMPLE_W'($urandom_range(400) - 200);
	endfunction

	// called just after a falling edge; returns just after a falling edge
	task automatic send_item(sample_t s, bit typed, mean_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_item <= s;
		row_typed <= typed;
		row_mean <= m;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		sample_t s;
		int idle_set [4];
		int stall_set [4];

		idle_set = '{0, 48, 0, 9};
		stall_set = '{0, 0, 48, 9};
		clear_average();
		plan = '{
			row(100, -100, 0, 0, 1, 100, -100, 0),          // empty window acts as restart
			row(32767, -32768, -1, 1, 1, 32767, -32768, -1),
			row(32767, -32768, -1, 0, 0),
			row(-32768, 32767, 0, 0, 0),
			row(0, 0, 0, 1, 1, 0, 0, 0),
			row(1, -1, 63, 0, 0),
			row(-1, 1, -63, 0, 0),
			row(-64, -65, 127, 0, 0),
			row(-1, -1, -1, 1, 1, -1, -1, -1),
			row(0, 0, 0, 0, 0),                             // -63/64 truncates to zero
			row(-32768, -32768, -32768, 1, 1, -32768, -32768, -32768),
			row(32767, 32767, 32767, 0, 0),
			row(21845, -21846, 4660, 1, 1, 21845, -21846, 4660),
			row(-21846, 21845, -4661, 0, 0),
			row(32767, 32767, 32767, 1, 1, 32767, 32767, 32767),
			row(-32768, -32768, -32768, 0, 0)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_item(plan[i].s, plan[i].typed, plan[i].m);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			rx_stall_pct = stall_set[p];
			// long output hold-off while items keep coming, so the core backs up
			if (p == 0)
				hold_len = 300;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				s.sample_x = rand_axis();
				s.sample_y = rand_axis();
				s.sample_z = rand_axis();
				s.restart = ($urandom_range(31) == 0);
				send_item(s, 1'b0, '0);
			end
			drain();
		end

		if (errors == 0)
			$display("three_axis_moving_average_core_tb OK");
		else
			$display("three_axis_moving_average_core_tb NOT OK");
		$finish;
	end

endmodule

### three_axis_moving_average_core.f
hw/rtl/tama_pkg.sv
hw/rtl/three_axis_moving_average_core.sv
tb/three_axis_moving_average_core_tb.sv
